@@ src/ptmr_pkg.sv @@
// ----------------------------------------------------------------------------
// ptmr_pkg: shared types and constants of the programmable interval timer
// Request codes, register offsets, control word layout, ident words and the
// per-channel control struct.
// ----------------------------------------------------------------------------
package ptmr_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  // word offsets
  localparam logic [3:0] OffIdentLast = 4'd5;
  localparam logic [3:0] OffFreqLo    = 4'd6;
  localparam logic [3:0] OffFreqHi    = 4'd7;
  localparam logic [3:0] OffPeriodLo  = 4'd8;
  localparam logic [3:0] OffPeriodHi  = 4'd9;
  localparam logic [3:0] OffControl   = 4'd10;
  localparam logic [3:0] OffPending   = 4'd11;

  // control word layout
  localparam int unsigned SelLsb   = 6;
  localparam int unsigned SelBits  = 4;
  localparam int unsigned PerShift = 10;
  localparam int unsigned MaxChan  = 6;

  // name length followed by the device name, high byte first
  localparam logic [15:0] IdentWords [6] = '{
    16'h0009, 16'h5052, 16'h4F47, 16'h5449, 16'h4D45, 16'h5200
  };

  typedef struct packed {
    logic tick;      // held request beat is a tick
    logic arm;       // enable bit toggled by a control write
    logic wr_lo;     // period low word write to this channel
    logic wr_hi;     // period high word write to this channel
    logic enabled;
    logic periodic;
  } chan_ctl_t;

endpackage

@@ src/ptmr_chan.sv @@
// ----------------------------------------------------------------------------
// ptmr_chan: one timer channel
// Holds period and deadline, tests the deadline against the tick interval
// and re-arms on a hit when periodic or on an enable toggle.
// ----------------------------------------------------------------------------
module ptmr_chan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                exec_i,
  input  ptmr_pkg::chan_ctl_t ctl_i,
  input  logic [15:0]         wdata_i,
  input  logic [63:0]         now_i,
  input  logic [63:0]         now_new_i,
  output logic [31:0]         period_o,
  output logic                fired_o
);
  import ptmr_pkg::*;

  logic [31:0] period_q, period_d;
  logic [63:0] deadline_q, deadline_d;
  logic        hit;

  // interval (now, now_new]; no hit when the time wraps within the tick
  assign hit = ctl_i.tick && ctl_i.enabled &&
               (deadline_q > now_i) && (deadline_q <= now_new_i);

  always_comb begin
    period_d   = period_q;
    deadline_d = deadline_q;
    if (exec_i) begin
      if (ctl_i.wr_lo) begin
        period_d[15:0] = wdata_i;
      end
      if (ctl_i.wr_hi) begin
        period_d[31:16] = wdata_i;
      end
      if (ctl_i.arm) begin
        deadline_d = now_i + {32'd0, period_q};
      end else if (hit && ctl_i.periodic) begin
        deadline_d = now_new_i + {32'd0, period_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= '0;
      deadline_q <= '0;
    end else begin
      period_q   <= period_d;
      deadline_q <= deadline_d;
    end
  end

  assign period_o = period_q;
  assign fired_o  = exec_i && hit;

endmodule

@@ src/multi_channel_programmable_timer.sv @@
// ----------------------------------------------------------------------------
// multi_channel_programmable_timer: register-mapped multi-channel timer
// Bus reads/writes of twelve word registers and time ticks, one result beat
// per request beat.
// ----------------------------------------------------------------------------
// channel   dir  tdata (low bit up)                              tuser
// s_axis    in   offset[3:0] write_data[19:4] delta_ns[43:20]    req_type[1:0]
// m_axis    out  read_data[15:0] irq_pulse[19:16]                -
//
// One beat per cycle while the result side does not stall; a result passes
// through the input register, then one execute step into the result reg.
// All channels are compared against the tick interval in parallel.
// Reset clears time, control, pending bitmap, periods and deadlines.
// A stalled result holds; the input register keeps one more beat behind it.
// ----------------------------------------------------------------------------
module multi_channel_programmable_timer #(
  parameter int unsigned NUM_TIMERS = 6,
  parameter int unsigned FREQ_HZ    = 1000000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // offset, write_data, delta_ns
  input  logic [1:0]  s_axis_tuser_i,   // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // read_data, irq_pulse
);
  import ptmr_pkg::*;

  localparam logic [31:0] FreqWord = 32'(FREQ_HZ);

  // input register
  logic        in_valid_q, in_valid_d;
  req_e        in_req_q;
  logic [3:0]  in_off_q;
  logic [15:0] in_wdata_q;
  logic [23:0] in_delta_q;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_rdata_q, out_rdata_d;
  logic [3:0]  out_irq_q, out_irq_d;

  // architectural state
  logic [63:0] now_q, now_d, now_new;
  logic [15:0] ctrl_q, ctrl_d;
  logic [15:0] pend_q, pend_d;

  logic                exec, s_fire;
  logic                is_wr, is_tick, sel_ok;
  logic [SelBits-1:0]  sel;
  logic [31:0]         sel_period;
  logic [31:0]         period_w [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] fired;
  chan_ctl_t           ctl [NUM_TIMERS];
  logic                any_hi;
  logic [3:0]          hi_bits;

  assign exec            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || exec;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign is_wr   = (in_req_q == REQ_WRITE);
  assign is_tick = (in_req_q == REQ_TICK);
  assign sel     = ctrl_q[SelLsb +: SelBits];
  assign sel_ok  = ({28'd0, sel} < 32'(NUM_TIMERS));
  assign now_new = now_q + {40'd0, in_delta_q};

  always_comb begin
    sel_period = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if ({28'd0, sel} == 32'(i)) begin
        sel_period = period_w[i];
      end
    end
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_chan
    assign ctl[g] = '{
      tick:     is_tick,
      arm:      is_wr && (in_off_q == OffControl) && (ctrl_q[g] ^ in_wdata_q[g]),
      wr_lo:    is_wr && (in_off_q == OffPeriodLo) && sel_ok && ({28'd0, sel} == 32'(g)),
      wr_hi:    is_wr && (in_off_q == OffPeriodHi) && sel_ok && ({28'd0, sel} == 32'(g)),
      enabled:  ctrl_q[g],
      periodic: ctrl_q[PerShift + g]
    };

    ptmr_chan u_chan (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .exec_i    (exec),
      .ctl_i     (ctl[g]),
      .wdata_i   (in_wdata_q),
      .now_i     (now_q),
      .now_new_i (now_new),
      .period_o  (period_w[g]),
      .fired_o   (fired[g])
    );
  end

  // channels 2 and up report through the pending bitmap and irq bit 3
  always_comb begin
    any_hi  = 1'b0;
    hi_bits = '0;
    for (int i = 2; i < NUM_TIMERS; i++) begin
      any_hi         = any_hi | fired[i];
      hi_bits[i - 2] = fired[i];
    end
  end

  // read mux
  always_comb begin
    out_rdata_d = '0;
    if (in_req_q == REQ_READ) begin
      if (in_off_q <= OffIdentLast) begin
        out_rdata_d = IdentWords[in_off_q[2:0]];
      end else begin
        case (in_off_q)
          OffFreqLo:   out_rdata_d = FreqWord[15:0];
          OffFreqHi:   out_rdata_d = FreqWord[31:16];
          OffPeriodLo: out_rdata_d = sel_ok ? sel_period[15:0] : 16'd0;
          OffPeriodHi: out_rdata_d = sel_ok ? sel_period[31:16] : 16'd0;
          OffControl:  out_rdata_d = ctrl_q;
          OffPending:  out_rdata_d = pend_q;
          default:     out_rdata_d = '0;
        endcase
      end
    end
  end

  always_comb begin
    out_irq_d = '0;
    if (is_tick) begin
      out_irq_d[0] = fired[0];
      out_irq_d[1] = fired[1];
      out_irq_d[3] = any_hi;
    end
  end

  always_comb begin
    now_d  = now_q;
    ctrl_d = ctrl_q;
    pend_d = pend_q;
    if (exec) begin
      unique case (in_req_q)
        REQ_WRITE: begin
          if (in_off_q == OffControl) begin
            ctrl_d = in_wdata_q;
          end
          if (in_off_q == OffPending) begin
            pend_d = in_wdata_q;
          end
        end
        REQ_TICK: begin
          now_d  = now_new;
          pend_d = pend_q | {12'd0, hi_bits};
        end
        REQ_READ, REQ_NOP: begin
        end
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (exec) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      now_q       <= '0;
      ctrl_q      <= '0;
      pend_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      now_q       <= now_d;
      ctrl_q      <= ctrl_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_req_q   <= req_e'(s_axis_tuser_i);
      in_off_q   <= s_axis_tdata_i[3:0];
      in_wdata_q <= s_axis_tdata_i[19:4];
      in_delta_q <= s_axis_tdata_i[43:20];
    end
    if (exec) begin
      out_rdata_q <= out_rdata_d;
      out_irq_q   <= out_irq_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_irq_q, out_rdata_q};

  // ready only drops while a beat waits behind a stalled result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a stalled result");

  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && in_req_q != REQ_READ) |=> (out_rdata_q == 16'd0))
    else $error("nonzero read_data on a non-read beat");

  a_irq_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && in_req_q != REQ_TICK) |=> (out_irq_q == 4'd0))
    else $error("irq_pulse set on a non-tick beat");

  a_now_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(exec && in_req_q == REQ_TICK) |=> $stable(now_q))
    else $error("time moved without a tick");

endmodule

@@ test/tb_multi_channel_programmable_timer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_channel_programmable_timer: self-checking bench of the timer
// Drives read, write, tick and no-op beats into the request stream. A local
// model of the register file and channel deadlines predicts every result
// beat, and the result beats are compared in order. Both sides idle at random.
// One long receiver stall backs the block up into its request side.
// ----------------------------------------------------------------------------
module tb_multi_channel_programmable_timer;
  import ptmr_pkg::*;

  localparam int unsigned NTimers     = 6;
  localparam int unsigned FreqHz      = 1000000;
  localparam logic [31:0] FreqWord    = FreqHz;
  localparam int          CycleLimit  = 200000;
  localparam int          RandomBeats = 1150;
  localparam int          DrainCycles = 16;

  typedef struct packed {
    logic [15:0] rd;
    logic [3:0]  irq;
  } resp_t;

  logic        clk;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  // timer model state
  logic [63:0] tmr_now;
  logic [15:0] tmr_ctrl;
  logic [15:0] tmr_pend;
  logic [31:0] tmr_period [NTimers];
  logic [63:0] tmr_deadline [NTimers];

  resp_t resp_q [$];
  int    beats_sent = 0;
  int    mismatches = 0;
  int    cycles     = 0;
  bit    tx_idle    = 1'b1;
  bit    rx_idle    = 1'b1;
  int    rx_hold    = 0;

  multi_channel_programmable_timer #(
    .NUM_TIMERS(NTimers),
    .FREQ_HZ   (FreqHz)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Applies one accepted beat to the model and returns the result it causes.
  function automatic resp_t timer_response(req_e req, logic [3:0] off, logic [15:0] wd,
                                           logic [23:0] dl);
    resp_t       r;
    logic [3:0]  sel;
    logic [63:0] old_t;
    bit          sel_ok;
    r      = '0;
    sel    = tmr_ctrl[SelLsb +: SelBits];
    sel_ok = (sel < NTimers);
    case (req)
      REQ_READ: begin
        if (off <= OffIdentLast) begin
          r.rd = IdentWords[off[2:0]];
        end else begin
          case (off)
            OffFreqLo:   r.rd = FreqWord[15:0];
            OffFreqHi:   r.rd = FreqWord[31:16];
            OffPeriodLo: if (sel_ok) r.rd = tmr_period[sel[2:0]][15:0];
            OffPeriodHi: if (sel_ok) r.rd = tmr_period[sel[2:0]][31:16];
            OffControl:  r.rd = tmr_ctrl;
            OffPending:  r.rd = tmr_pend;
            default:     r.rd = '0;
          endcase
        end
      end
      REQ_WRITE: begin
        case (off)
          OffPeriodLo: if (sel_ok) tmr_period[sel[2:0]][15:0] = wd;
          OffPeriodHi: if (sel_ok) tmr_period[sel[2:0]][31:16] = wd;
          OffControl: begin
            // a toggled enable re-arms the channel from the current time
            for (int i = 0; i < NTimers; i++) begin
              if (tmr_ctrl[i] != wd[i]) tmr_deadline[i] = tmr_now + 64'(tmr_period[i]);
            end
            tmr_ctrl = wd;
          end
          OffPending:  tmr_pend = wd;
          default: ;
        endcase
      end
      REQ_TICK: begin
        old_t   = tmr_now;
        tmr_now = tmr_now + 64'(dl);
        for (int i = 0; i < NTimers; i++) begin
          if (tmr_ctrl[i] && tmr_deadline[i] > old_t && tmr_deadline[i] <= tmr_now) begin
            if (i < 2) begin
              r.irq[i] = 1'b1;
            end else begin
              tmr_pend[i - 2] = 1'b1;
              r.irq[3]        = 1'b1;
            end
            if (tmr_ctrl[PerShift + i]) tmr_deadline[i] = tmr_now + 64'(tmr_period[i]);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Valid stays high from one beat to the next unless a gap is drawn.
  task automatic send_beat(req_e req, logic [3:0] off, logic [15:0] wd, logic [23:0] dl);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {4'b0, dl, wd, off};
    do @(posedge clk); while (!s_tready);
    resp_q.push_back(timer_response(req, off, wd, dl));
    beats_sent++;
  endtask

  // result side: random stalls, optional long hold, in-order compare
  initial begin : rx_side
    int    wait_n;
    resp_t got;
    resp_t want;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        while (rx_hold > 0) begin
          @(posedge clk);
          rx_hold--;
        end
      end else begin
        wait_n = rx_idle ? $urandom_range(0, 3) : 0;
        if (wait_n > 0) begin
          m_tready <= 1'b0;
          repeat (wait_n) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.rd  = m_tdata[15:0];
      got.irq = m_tdata[19:16];
      if (resp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: rd=%h irq=%h", got.rd, got.irq);
      end else begin
        want = resp_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected rd=%h irq=%h, got rd=%h irq=%h",
                     want.rd, want.irq, got.rd, got.irq);
        end
      end
    end
  end

  task automatic test_ident_regs();
    send_beat(REQ_READ, 4'd0, '0, '0);
    send_beat(REQ_READ, OffIdentLast, '0, '0);
    send_beat(REQ_READ, OffFreqLo, '0, '0);
    send_beat(REQ_READ, OffFreqHi, '0, '0);
    send_beat(REQ_READ, 4'd15, '0, '0);
  endtask

  task automatic test_read_only_writes();
    send_beat(REQ_WRITE, 4'd0, 16'hFFFF, '0);
    send_beat(REQ_WRITE, OffFreqLo, 16'hFFFF, '0);
    send_beat(REQ_WRITE, 4'd12, 16'hFFFF, '0);
    send_beat(REQ_READ, OffFreqLo, '0, '0);
  endtask

  task automatic test_period_regs();
    send_beat(REQ_WRITE, OffPeriodLo, 16'd100, '0);
    send_beat(REQ_WRITE, OffPeriodHi, 16'hFFFF, '0);
    // high word is replaced, not accumulated
    send_beat(REQ_WRITE, OffPeriodHi, 16'h0000, '0);
    send_beat(REQ_READ, OffPeriodHi, '0, '0);
    // select beyond the channel count
    send_beat(REQ_WRITE, OffControl, 16'(7 << SelLsb), '0);
    send_beat(REQ_WRITE, OffPeriodLo, 16'hFFFF, '0);
    send_beat(REQ_READ, OffPeriodLo, '0, '0);
  endtask

  task automatic test_tick_fire();
    send_beat(REQ_WRITE, OffControl, 16'(1 | (1 << PerShift)), '0);
    send_beat(REQ_TICK, '0, '0, 24'd0);
    send_beat(REQ_TICK, '0, '0, 24'd100);
    send_beat(REQ_TICK, '0, '0, 24'hFFFFFF);
  endtask

  task automatic test_pending_and_nop();
    send_beat(REQ_WRITE, OffPending, 16'hFFFF, '0);
    send_beat(REQ_READ, OffPending, '0, '0);
    send_beat(REQ_NOP, 4'hF, 16'hFFFF, 24'hFFFFFF);
    send_beat(REQ_READ, OffControl, '0, '0);
  endtask

  // receiver holds off while requests keep coming, so the input side stalls
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 200;
    for (int i = 0; i < 24; i++) begin
      send_beat(req_e'(i % 3), 4'($urandom_range(8, 11)), '0, 24'($urandom_range(0, 200)));
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    int          stop_at;
    int          next_switch;
    int          kind;
    int          mode;
    logic [15:0] cw;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [23:0] dl;
    stop_at     = beats_sent + RandomBeats;
    next_switch = beats_sent;
    while (beats_sent < stop_at) begin
      if (beats_sent >= next_switch) begin
        next_switch = beats_sent + 100;
        mode        = $urandom_range(0, 3);
        tx_idle     = mode[0];
        rx_idle     = mode[1];
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_beat(req_e'($urandom_range(0, 3)), 4'($urandom), 16'($urandom), 24'($urandom));
      end else if (kind <= 2) begin
        // pick a channel (sometimes out of range) and load its period
        cw                       = tmr_ctrl;
        cw[SelLsb +: SelBits]    = 4'($urandom_range(0, 7));
        lo = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3000));
        hi = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h0000;
        send_beat(REQ_WRITE, OffControl, cw, 24'($urandom));
        send_beat(REQ_WRITE, OffPeriodLo, lo, 24'($urandom));
        send_beat(REQ_WRITE, OffPeriodHi, hi, 24'($urandom));
        send_beat(REQ_READ, 4'($urandom_range(OffPeriodLo, OffPeriodHi)), 16'($urandom), '0);
      end else if (kind == 3) begin
        send_beat(REQ_WRITE, OffControl, 16'($urandom), 24'($urandom));
      end else if (kind == 4) begin
        send_beat(REQ_READ, 4'($urandom_range(8, 11)), 16'($urandom), 24'($urandom));
        if ($urandom_range(0, 3) == 0)
          send_beat(REQ_WRITE, OffPending, ($urandom_range(0, 1) != 0) ? 16'($urandom) : '0,
                    '0);
      end else begin
        dl = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1500));
        send_beat(REQ_TICK, 4'($urandom), 16'($urandom), dl);
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    tmr_now  = '0;
    tmr_ctrl = '0;
    tmr_pend = '0;
    for (int i = 0; i < NTimers; i++) begin
      tmr_period[i]   = '0;
      tmr_deadline[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ident_regs();
    test_read_only_writes();
    test_period_regs();
    test_tick_fire();
    test_pending_and_nop();
    test_backpressure();
    test_random_traffic();

    s_tvalid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/ptmr_pkg.sv
src/ptmr_chan.sv
src/multi_channel_programmable_timer.sv
test/tb_multi_channel_programmable_timer.sv
